// ===== rtl/core/akd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// akd_pkg
// Shared types, codes and constants of the ladder ADC key debouncer.
// ----------------------------------------------------------------------------
package akd_pkg;

    // key count, key positions and field widths
    localparam int NUM_KEYS   = 6;
    localparam int NUM_LADDER = 4;
    localparam int INFRA_IDX  = 5;
    localparam int ADC_SHIFT  = 2;
    localparam int ADC_W      = 10;
    localparam int CODE_W     = 8;
    localparam int COUNT_W    = 9;
    localparam int IDX_W      = 3;

    // active level of each key, bit i for key i+1 (infrared is active high)
    localparam logic [NUM_KEYS-1:0] KEY_ACTIVE = 6'b100000;
    // keys whose active stable level survives a stable read
    localparam logic [NUM_KEYS-1:0] KEY_KEEP   = 6'b100000;

    // configuration register reset values
    localparam logic [7:0] K1_CENTER_RST  = 8'd32;
    localparam logic [7:0] K2_CENTER_RST  = 8'd96;
    localparam logic [7:0] K3_CENTER_RST  = 8'd160;
    localparam logic [7:0] K4_CENTER_RST  = 8'd224;
    localparam logic [7:0] WINDOW_RST     = 8'd8;
    localparam logic [7:0] DEB_TICKS_RST  = 8'd5;
    localparam logic       INFRA_EN_RST   = 1'b1;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_K1_CENTER   = 3'd0,
        REG_K2_CENTER   = 3'd1,
        REG_K3_CENTER   = 3'd2,
        REG_K4_CENTER   = 3'd3,
        REG_WINDOW      = 3'd4,
        REG_DEB_TICKS   = 3'd5,
        REG_INFRA_EN    = 3'd6,
        REG_UNUSED      = 3'd7
    } reg_idx_t;

    // request opcodes
    typedef enum logic [1:0] {
        OP_SAMPLE   = 2'd0,
        OP_READ_CUR = 2'd1,
        OP_READ_STB = 2'd2,
        OP_NOP      = 2'd3
    } op_t;

    // per-key level codes
    typedef enum logic [1:0] {
        LVL_LOW  = 2'd0,
        LVL_HIGH = 2'd1,
        LVL_NONE = 2'd2,
        LVL_RSVD = 2'd3
    } lvl_t;

    // reported key status
    typedef enum logic [1:0] {
        ST_INACTIVE = 2'd0,
        ST_ACTIVE   = 2'd1,
        ST_UNSTABLE = 2'd2,
        ST_RSVD     = 2'd3
    } status_t;

    // command into one debounce lane
    typedef struct packed {
        logic tick;
        logic level_in;
        logic stable_rd;
    } lane_cmd_t;

    // what one lane reports to the merge stage
    typedef struct packed {
        logic    cur_active;
        logic    cur_high;
        status_t stable_code;
    } lane_stat_t;

    // code inside [max(0, center - window), min(255, center + window)]
    function automatic logic in_window(
        input logic [CODE_W-1:0] code,
        input logic [CODE_W-1:0] center,
        input logic [CODE_W-1:0] window
    );
        logic [CODE_W:0]   sum;
        logic [CODE_W-1:0] hi;
        logic [CODE_W-1:0] lo;
        sum = {1'b0, center} + {1'b0, window};
        hi  = sum[CODE_W] ? {CODE_W{1'b1}} : sum[CODE_W-1:0];
        lo  = (center > window) ? center - window : '0;
        return (code <= hi) && (code >= lo);
    endfunction

endpackage

// ===== rtl/core/akd_ladder_dec.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// akd_ladder_dec
// Turns one ladder ADC sample into the raw levels of the four ladder keys.
// ----------------------------------------------------------------------------
module akd_ladder_dec (
    input  logic [akd_pkg::ADC_W-1:0]      adc_sample,
    input  logic [akd_pkg::CODE_W-1:0]     center [akd_pkg::NUM_LADDER],
    input  logic [akd_pkg::CODE_W-1:0]     window,
    output logic [akd_pkg::NUM_LADDER-1:0] ladder_lvl
);
    import akd_pkg::*;

    logic [ADC_W-1:0]      shifted;
    logic [CODE_W-1:0]     code;
    logic [NUM_LADDER-1:0] hit;

    // scale the sample down to an 8-bit code
    assign shifted = adc_sample >> ADC_SHIFT;
    assign code    = shifted[CODE_W-1:0];

    // window compare for every ladder key in parallel
    always_comb begin
        for (int i = 0; i < NUM_LADDER; i++) begin
            hit[i] = in_window(code, center[i], window);
        end
    end

    // first matching key is pressed (low), the others read high
    always_comb begin
        ladder_lvl = '1;
        for (int i = NUM_LADDER - 1; i >= 0; i--) begin
            if (hit[i]) begin
                ladder_lvl    = '1;
                ladder_lvl[i] = 1'b0;
            end
        end
    end

endmodule

// ===== rtl/core/akd_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// akd_lane
// Debounce lane of one key: last level, run counter and latched level.
// ----------------------------------------------------------------------------
module akd_lane (
    input  logic               aclk,
    input  logic               aresetn,
    input  akd_pkg::lane_cmd_t cmd,
    input  logic [7:0]         debounce_ticks,
    input  logic               active_level,
    input  logic               keep_active,
    output akd_pkg::lane_stat_t stat
);
    import akd_pkg::*;

    lvl_t               level_reg,  level_next;
    lvl_t               stable_reg, stable_next;
    logic [COUNT_W-1:0] count_reg,  count_next;
    lvl_t               lvl_new;
    lvl_t               act;
    logic [COUNT_W-1:0] ticks_ext;

    assign lvl_new   = cmd.level_in ? LVL_HIGH : LVL_LOW;
    assign act       = active_level ? LVL_HIGH : LVL_LOW;
    assign ticks_ext = {1'b0, debounce_ticks};

    // debounce update on a tick, latched level cleared on a stable read unless it is a kept active level
    always_comb begin
        level_next  = level_reg;
        stable_next = stable_reg;
        count_next  = count_reg;
        if (cmd.tick) begin
            level_next = lvl_new;
            if (lvl_new != level_reg) begin
                count_next  = '0;
                stable_next = LVL_NONE;
            end else if (count_reg < ticks_ext) begin
                count_next = count_reg + COUNT_W'(1);
            end else if (count_reg == ticks_ext) begin
                stable_next = lvl_new;
                count_next  = count_reg + COUNT_W'(1);
            end
        end else if (cmd.stable_rd) begin
            if (!(keep_active && stable_reg == act)) begin
                stable_next = LVL_NONE;
            end
        end
    end

    // lane state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg  <= LVL_NONE;
            stable_reg <= LVL_NONE;
            count_reg  <= '0;
        end else begin
            level_reg  <= level_next;
            stable_reg <= stable_next;
            count_reg  <= count_next;
        end
    end

    // status seen by the merge stage
    always_comb begin
        stat.cur_active = (level_reg == act);
        stat.cur_high   = (level_reg == LVL_HIGH);
        if (stable_reg == act) begin
            stat.stable_code = ST_ACTIVE;
        end else if (stable_reg == LVL_NONE) begin
            stat.stable_code = ST_UNSTABLE;
        end else begin
            stat.stable_code = ST_INACTIVE;
        end
    end

endmodule

// ===== rtl/core/akd_merge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// akd_merge
// Picks the answer of the addressed lane, builds the level bitmap and holds
// results in an output register with a skid stage.
// ----------------------------------------------------------------------------
module akd_merge (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          accept,
    input  akd_pkg::op_t                  op,
    input  logic [akd_pkg::IDX_W-1:0]     key_idx,
    input  logic                          id_valid,
    input  logic                          infra_en,
    input  akd_pkg::lane_stat_t           stats [akd_pkg::NUM_KEYS],
    input  logic [akd_pkg::NUM_KEYS-1:0]  new_levels,
    output logic                          in_ready,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata   // key_status[1:0], current_levels[7:2]
);
    import akd_pkg::*;

    status_t             status;
    logic [NUM_KEYS-1:0] bitmap;
    logic [7:0]          result;
    logic [7:0]          out_reg,  skid_reg;
    logic                out_valid_reg, skid_valid_reg;
    logic                masked;

    // infrared key answers inactive while disabled
    assign masked = (key_idx == IDX_W'(INFRA_IDX)) && !infra_en;

    // answer of the addressed lane
    always_comb begin
        status = ST_INACTIVE;
        for (int i = 0; i < NUM_KEYS; i++) begin
            if (id_valid && !masked && key_idx == IDX_W'(i)) begin
                if (op == OP_READ_CUR) begin
                    status = stats[i].cur_active ? ST_ACTIVE : ST_INACTIVE;
                end else if (op == OP_READ_STB) begin
                    status = stats[i].stable_code;
                end
            end
        end
    end

    // level bitmap after this request
    always_comb begin
        for (int i = 0; i < NUM_KEYS; i++) begin
            bitmap[i] = (op == OP_SAMPLE) ? new_levels[i] : stats[i].cur_high;
        end
    end

    assign result = {bitmap, status};

    // output register with skid stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (!out_valid_reg || m_tready) begin
                if (skid_valid_reg) begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end else begin
                    out_valid_reg <= accept;
                end
            end else if (accept) begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    // payload of output and skid stage
    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                out_reg <= skid_reg;
            end else if (accept) begin
                out_reg <= result;
            end
        end else if (accept) begin
            skid_reg <= result;
        end
    end

    assign in_ready = !skid_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

endmodule

// ===== rtl/core/adc_ladder_key_debouncer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adc_ladder_key_debouncer_top
// Six-key debouncer: four keys from a resistor ladder ADC, two direct pins.
// ----------------------------------------------------------------------------
// Takes one request per clock cycle while s_tready is high and answers every
// request with one result. Six debounce lanes, one per key, update together
// on a sample tick; a read addresses one lane and the merge stage selects
// its answer. The result sits in an output register backed by a skid
// stage, so s_tready is registered and stays high while up to one result
// waits on a stalled output. Configuration is over APB at byte address
// 4*i: ladder centers 1-4, match window, debounce ticks, infrared enable.
// ----------------------------------------------------------------------------
module adc_ladder_key_debouncer_top (
    input  logic        aclk,
    input  logic        aresetn,
    // request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // adc_sample[9:0], pin_key5[10], pin_infra[11],
                                   // key_id[14:12], zero[15]
    input  logic [1:0]  s_tuser,   // opcode[1:0]
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // key_status[1:0], current_levels[7:2]
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import akd_pkg::*;

    logic [CODE_W-1:0]     center_reg [NUM_LADDER];
    logic [CODE_W-1:0]     window_reg;
    logic [7:0]            ticks_reg;
    logic                  infra_en_reg;
    reg_idx_t              reg_idx;
    logic                  cfg_wr;

    logic                  accept;
    op_t                   op;
    logic [ADC_W-1:0]      adc_sample;
    logic                  pin_key5;
    logic                  pin_infra;
    logic [IDX_W-1:0]      key_id;
    logic [IDX_W-1:0]      key_idx;
    logic                  id_valid;
    logic [NUM_LADDER-1:0] ladder_lvl;
    logic [NUM_KEYS-1:0]   new_levels;
    lane_cmd_t             cmds  [NUM_KEYS];
    lane_stat_t            stats [NUM_KEYS];

    // request fields
    assign op         = op_t'(s_tuser);
    assign adc_sample = s_tdata[9:0];
    assign pin_key5   = s_tdata[10];
    assign pin_infra  = s_tdata[11];
    assign key_id     = s_tdata[14:12];
    assign key_idx    = key_id - IDX_W'(1);
    assign id_valid   = (key_id >= IDX_W'(1)) && (key_id <= IDX_W'(NUM_KEYS));
    assign accept     = s_tvalid && s_tready;

    // configuration registers
    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[4:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_reg[0] <= K1_CENTER_RST;
            center_reg[1] <= K2_CENTER_RST;
            center_reg[2] <= K3_CENTER_RST;
            center_reg[3] <= K4_CENTER_RST;
            window_reg    <= WINDOW_RST;
            ticks_reg     <= DEB_TICKS_RST;
            infra_en_reg  <= INFRA_EN_RST;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_K1_CENTER: center_reg[0] <= pwdata[7:0];
                REG_K2_CENTER: center_reg[1] <= pwdata[7:0];
                REG_K3_CENTER: center_reg[2] <= pwdata[7:0];
                REG_K4_CENTER: center_reg[3] <= pwdata[7:0];
                REG_WINDOW:    window_reg    <= pwdata[7:0];
                REG_DEB_TICKS: ticks_reg     <= pwdata[7:0];
                REG_INFRA_EN:  infra_en_reg  <= pwdata[0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        unique case (reg_idx)
            REG_K1_CENTER: prdata = {24'd0, center_reg[0]};
            REG_K2_CENTER: prdata = {24'd0, center_reg[1]};
            REG_K3_CENTER: prdata = {24'd0, center_reg[2]};
            REG_K4_CENTER: prdata = {24'd0, center_reg[3]};
            REG_WINDOW:    prdata = {24'd0, window_reg};
            REG_DEB_TICKS: prdata = {24'd0, ticks_reg};
            REG_INFRA_EN:  prdata = {31'd0, infra_en_reg};
            default:       prdata = '0;
        endcase
    end

    // ladder decode
    akd_ladder_dec u_ladder_dec (
        .adc_sample (adc_sample),
        .center     (center_reg),
        .window     (window_reg),
        .ladder_lvl (ladder_lvl)
    );

    assign new_levels = {pin_infra, pin_key5, ladder_lvl};

    // one debounce lane per key
    for (genvar g = 0; g < NUM_KEYS; g++) begin : g_lane
        assign cmds[g].tick      = accept && (op == OP_SAMPLE);
        assign cmds[g].level_in  = new_levels[g];
        assign cmds[g].stable_rd = accept && (op == OP_READ_STB) && id_valid
                                   && (key_idx == IDX_W'(g))
                                   && !((g == INFRA_IDX) && !infra_en_reg);

        akd_lane u_lane (
            .aclk           (aclk),
            .aresetn        (aresetn),
            .cmd            (cmds[g]),
            .debounce_ticks (ticks_reg),
            .active_level   (KEY_ACTIVE[g]),
            .keep_active    (KEY_KEEP[g]),
            .stat           (stats[g])
        );
    end

    // answer selection and output staging
    akd_merge u_merge (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .op         (op),
        .key_idx    (key_idx),
        .id_valid   (id_valid),
        .infra_en   (infra_en_reg),
        .stats      (stats),
        .new_levels (new_levels),
        .in_ready   (s_tready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

// ===== dv/adc_ladder_key_debouncer_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adc_ladder_key_debouncer_top_tb
// Self-checking bench for the six-key ladder ADC debouncer.
// ----------------------------------------------------------------------------
// Streams sample ticks and key reads into the block and checks every result
// against a cycle-free predictor of the keys, their debounce runs and their
// latched levels. A directed opening covers the edge cases. Random runs of
// held ladder codes with reads in between follow, under several register
// settings written over APB. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module adc_ladder_key_debouncer_top_tb;
    import akd_pkg::*;

    // one expected result: key status and current levels
    typedef struct packed {
        status_t    status;
        logic [5:0] levels;
    } key_report_t;

    // predictor of the key levels plus queue of expected results
    class keypad_scoreboard;
        logic [7:0]  centers [NUM_LADDER];
        logic [7:0]  window;
        logic [7:0]  deb_ticks;
        logic        infra_en;
        lvl_t        now_lvl  [NUM_KEYS];
        lvl_t        held_lvl [NUM_KEYS];
        int unsigned run_len  [NUM_KEYS];
        key_report_t pending_reports [$];
        int          errors;
        int          requests;
        int          ticks;
        int          reads;
        int          checked;

        function new();
            centers[0] = K1_CENTER_RST;
            centers[1] = K2_CENTER_RST;
            centers[2] = K3_CENTER_RST;
            centers[3] = K4_CENTER_RST;
            window     = WINDOW_RST;
            deb_ticks  = DEB_TICKS_RST;
            infra_en   = INFRA_EN_RST;
            for (int k = 0; k < NUM_KEYS; k++) begin
                now_lvl[k]  = LVL_NONE;
                held_lvl[k] = LVL_NONE;
                run_len[k]  = 0;
            end
            errors   = 0;
            requests = 0;
            ticks    = 0;
            reads    = 0;
            checked  = 0;
        endfunction

        function void set_reg(reg_idx_t idx, logic [7:0] val);
            case (idx)
                REG_K1_CENTER: centers[0] = val;
                REG_K2_CENTER: centers[1] = val;
                REG_K3_CENTER: centers[2] = val;
                REG_K4_CENTER: centers[3] = val;
                REG_WINDOW:    window     = val;
                REG_DEB_TICKS: deb_ticks  = val;
                REG_INFRA_EN:  infra_en   = val[0];
                default: ;
            endcase
        endfunction

        // infrared is active high, every other key active low
        function lvl_t active_lvl(int k);
            return (k == INFRA_IDX) ? LVL_HIGH : LVL_LOW;
        endfunction

        // window bounds clamp to the 8-bit code range
        function bit near(int code, int center);
            int lo;
            int hi;
            hi = center + int'(window);
            lo = center - int'(window);
            if (hi > 255) hi = 255;
            if (lo < 0) lo = 0;
            return (code >= lo) && (code <= hi);
        endfunction

        // decode the ladder, then run every key's debounce counter
        function void tick(logic [9:0] adc, logic p5, logic pir);
            int   code;
            lvl_t fresh [NUM_KEYS];
            bit   matched;
            code = int'(adc >> ADC_SHIFT) & 255;
            for (int k = 0; k < NUM_LADDER; k++) fresh[k] = LVL_HIGH;
            fresh[4]         = p5  ? LVL_HIGH : LVL_LOW;
            fresh[INFRA_IDX] = pir ? LVL_HIGH : LVL_LOW;
            matched = 1'b0;
            for (int k = 0; k < NUM_LADDER; k++) begin
                if (!matched && near(code, int'(centers[k]))) begin
                    fresh[k] = LVL_LOW;
                    matched  = 1'b1;
                end
            end
            for (int k = 0; k < NUM_KEYS; k++) begin
                if (fresh[k] != now_lvl[k]) begin
                    run_len[k]  = 0;
                    held_lvl[k] = LVL_NONE;
                end else if (run_len[k] < deb_ticks) begin
                    run_len[k]++;
                end else if (run_len[k] == deb_ticks) begin
                    held_lvl[k] = fresh[k];
                    run_len[k]++;
                end
                now_lvl[k] = fresh[k];
            end
        endfunction

        function status_t read_now(int k);
            if (k == INFRA_IDX && !infra_en) return ST_INACTIVE;
            return (now_lvl[k] == active_lvl(k)) ? ST_ACTIVE : ST_INACTIVE;
        endfunction

        // a stable read consumes the latch, except an active infrared key
        function status_t read_held(int k);
            if (k == INFRA_IDX && !infra_en) return ST_INACTIVE;
            if (held_lvl[k] == active_lvl(k)) begin
                if (k != INFRA_IDX) held_lvl[k] = LVL_NONE;
                return ST_ACTIVE;
            end
            if (held_lvl[k] == LVL_NONE) return ST_UNSTABLE;
            held_lvl[k] = LVL_NONE;
            return ST_INACTIVE;
        endfunction

        // note an accepted request and queue the result it must give
        function void take_request(op_t op, logic [9:0] adc, logic p5, logic pir,
                                   logic [2:0] id);
            key_report_t want;
            int          k;
            bit          known;
            k     = int'(id) - 1;
            known = (id >= 3'd1) && (id <= 3'(NUM_KEYS));
            want.status = ST_INACTIVE;
            requests++;
            case (op)
                OP_SAMPLE: begin
                    tick(adc, p5, pir);
                    ticks++;
                end
                OP_READ_CUR: begin
                    reads++;
                    if (known) want.status = read_now(k);
                end
                OP_READ_STB: begin
                    reads++;
                    if (known) want.status = read_held(k);
                end
                default: ;
            endcase
            for (int i = 0; i < NUM_KEYS; i++) want.levels[i] = (now_lvl[i] == LVL_HIGH);
            pending_reports.push_back(want);
        endfunction

        task report(string msg);
            $display("[%0t] MISMATCH %s", $time, msg);
            errors++;
        endtask

        task check_report(logic [1:0] st, logic [5:0] lv);
            key_report_t want;
            if (pending_reports.size() == 0) begin
                report($sformatf("result with no request waiting: status %0d levels %02h",
                                 st, lv));
                return;
            end
            want = pending_reports.pop_front();
            checked++;
            if (st !== want.status)
                report($sformatf("result %0d: key_status %0d, expected %0d",
                                 checked, st, want.status));
            if (lv !== want.levels)
                report($sformatf("result %0d: current_levels %02h, expected %02h",
                                 checked, lv, want.levels));
        endtask

        task flush_leftovers();
            if (pending_reports.size() != 0) begin
                report($sformatf("%0d results never arrived", pending_reports.size()));
                pending_reports.delete();
            end
        endtask
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // adc_sample[9:0], pin_key5[10], pin_infra[11],
                            // key_id[14:12], zero[15]
    logic [1:0]  s_tuser;   // opcode[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;   // key_status[1:0], current_levels[7:2]
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    keypad_scoreboard sb;
    bit               steady = 1'b0;
    int               phases = 0;

    adc_ladder_key_debouncer_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // clock
    initial begin
        forever #5 aclk = ~aclk;
    end

    // result side: check each accepted result, stall at random
    always @(posedge aclk) begin
        if (aresetn === 1'b1 && m_tvalid && m_tready)
            sb.check_report(m_tdata[1:0], m_tdata[7:2]);
        m_tready <= steady || ($urandom_range(0, 99) >= 20);
    end

    // present one request and wait for its handshake; valid stays high after
    task automatic send_req(input op_t op, input logic [9:0] adc, input logic p5,
                            input logic pir, input logic [2:0] id);
        while (!steady && $urandom_range(0, 99) < 20) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, id, pir, p5, adc};
        s_tuser  <= op;
        do @(posedge aclk); while (!s_tready);
        sb.take_request(op, adc, p5, pir, id);
    endtask

    // apb write: setup cycle then access cycle until pready
    task automatic write_reg(input reg_idx_t idx, input logic [7:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'd0, val};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.set_reg(idx, val);
    endtask

    task automatic configure(input logic [7:0] c1, input logic [7:0] c2,
                             input logic [7:0] c3, input logic [7:0] c4,
                             input logic [7:0] win, input logic [7:0] deb,
                             input logic ir_en);
        write_reg(REG_K1_CENTER, c1);
        write_reg(REG_K2_CENTER, c2);
        write_reg(REG_K3_CENTER, c3);
        write_reg(REG_K4_CENTER, c4);
        write_reg(REG_WINDOW, win);
        write_reg(REG_DEB_TICKS, deb);
        write_reg(REG_INFRA_EN, {7'd0, ir_en});
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        phases++;
    endtask

    // drain every outstanding result, then let the pipeline settle
    task automatic wait_idle();
        int guard;
        guard = 0;
        s_tvalid <= 1'b0;
        while (sb.pending_reports.size() != 0 && guard < 5000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (4) @(posedge aclk);
        sb.flush_leftovers();
    endtask

    task automatic hold_samples(input logic [9:0] adc, input logic p5, input logic pir,
                                input int n);
        repeat (n) send_req(OP_SAMPLE, adc, p5, pir, 3'd0);
    endtask

    task automatic read_stable_all();
        for (int id = 1; id <= NUM_KEYS; id++) send_req(OP_READ_STB, 10'd0, 1'b0, 1'b0, 3'(id));
    endtask

    // held ladder codes with reads in between, plus noise samples and nops
    task automatic run_random(input int n);
        int         sent;
        int         hold;
        int         span;
        int         c;
        int         r;
        logic [7:0] code;
        logic       p5;
        logic       pir;
        sent = 0;
        while (sent < n) begin
            if ($urandom_range(0, 99) < 75) begin
                span = int'(sb.window);
                c = int'(sb.centers[$urandom_range(0, NUM_LADDER - 1)])
                    + int'($urandom_range(0, 2 * span)) - span;
                if (c < 0) c = 0;
                if (c > 255) c = 255;
                code = 8'(c);
            end else begin
                code = 8'($urandom_range(0, 255));
            end
            p5   = 1'($urandom_range(0, 1));
            pir  = 1'($urandom_range(0, 1));
            span = int'(sb.deb_ticks) + 4;
            if (span > 40) span = 40;
            hold = $urandom_range(1, span);
            while (hold > 0) begin
                r = $urandom_range(0, 99);
                if (r < 60) begin
                    hold--;
                    if (r < 3)
                        send_req(OP_SAMPLE, 10'($urandom), 1'($urandom), 1'($urandom),
                                 3'($urandom));
                    else
                        send_req(OP_SAMPLE, {code, 2'($urandom_range(0, 3))}, p5, pir,
                                 3'($urandom));
                end else if (r < 95) begin
                    send_req((r < 78) ? OP_READ_CUR : OP_READ_STB, 10'($urandom),
                             1'($urandom), 1'($urandom),
                             (r % 10 == 0) ? 3'($urandom_range(0, 7))
                                           : 3'($urandom_range(1, NUM_KEYS)));
                end else begin
                    send_req(OP_NOP, 10'($urandom), 1'($urandom), 1'($urandom),
                             3'($urandom));
                end
                sent++;
            end
        end
    endtask

    // stimulus
    initial begin
        sb = new();
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= OP_NOP;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // reads before any sample, out-of-range key ids, nop
        send_req(OP_READ_CUR, 10'd0, 1'b0, 1'b0, 3'd1);
        send_req(OP_READ_STB, 10'd0, 1'b0, 1'b0, 3'd1);
        send_req(OP_READ_STB, 10'd0, 1'b0, 1'b0, 3'd6);
        send_req(OP_READ_CUR, 10'h3FF, 1'b1, 1'b1, 3'd0);
        send_req(OP_READ_STB, 10'h3FF, 1'b1, 1'b1, 3'd7);
        send_req(OP_NOP, 10'h2AA, 1'b1, 1'b0, 3'd5);
        // code extremes and each ladder key, window edges included
        send_req(OP_SAMPLE, 10'd0, 1'b0, 1'b0, 3'd0);
        send_req(OP_SAMPLE, 10'h3FF, 1'b1, 1'b1, 3'd7);
        send_req(OP_SAMPLE, {8'd24, 2'd0}, 1'b1, 1'b0, 3'd0);
        send_req(OP_SAMPLE, {8'd96, 2'd3}, 1'b0, 1'b1, 3'd0);
        send_req(OP_SAMPLE, {8'd160, 2'd1}, 1'b1, 1'b1, 3'd0);
        send_req(OP_SAMPLE, {8'd232, 2'd2}, 1'b0, 1'b0, 3'd0);
        // hold key one at its upper edge long enough to latch
        hold_samples({8'd40, 2'd0}, 1'b0, 1'b1, 7);
        read_stable_all();
        // infrared stays latched, key one was consumed
        send_req(OP_READ_STB, 10'd0, 1'b0, 1'b0, 3'd6);
        send_req(OP_READ_STB, 10'd0, 1'b0, 1'b0, 3'd1);
        send_req(OP_READ_CUR, 10'd0, 1'b0, 1'b0, 3'd5);
        run_random(150);
        wait_idle();

        // zero window, zero debounce, infrared disabled
        configure(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'd0, 8'd0, 1'b0);
        run_random(150);
        wait_idle();

        // full window: key one swallows every code
        configure(8'd0, 8'd255, 8'd128, 8'd64, 8'd255, 8'd1, 1'b1);
        run_random(60);
        wait_idle();

        // centers at the code ends, clamped bounds
        configure(8'd0, 8'd255, 8'd8, 8'd247, 8'd10, 8'd3, 1'b1);
        run_random(60);
        wait_idle();

        // longest debounce: one long hold of ladder key two
        configure(8'd40, 8'd100, 8'd170, 8'd230, 8'd20, 8'd255, 1'b1);
        hold_samples({8'd100, 2'd1}, 1'b0, 1'b1, 262);
        read_stable_all();
        run_random(40);
        wait_idle();

        // back-to-back stretch with no idling on either side
        steady = 1'b1;
        configure(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                  8'($urandom_range(3, 30)), 8'($urandom_range(2, 8)), 1'b1);
        run_random(120);
        wait_idle();
        steady = 1'b0;

        // random settings throughout
        configure(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                  8'($urandom_range(0, 40)), 8'($urandom_range(0, 12)),
                  1'($urandom_range(0, 1)));
        run_random(120);
        wait_idle();

        $display("covered %0d requests: %0d sample ticks, %0d reads, %0d results checked",
                 sb.requests, sb.ticks, sb.reads, sb.checked);
        $display("across %0d register settings, window and debounce from zero to full scale",
                 phases + 1);
        if (sb.errors == 0) begin
            $display("adc_ladder_key_debouncer_top test passed");
        end else begin
            $display("adc_ladder_key_debouncer_top test failed");
        end
        $finish;
    end

    // run limit
    initial begin
        #2_000_000;
        $display("adc_ladder_key_debouncer_top test failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/akd_pkg.sv
rtl/core/akd_ladder_dec.sv
rtl/core/akd_lane.sv
rtl/core/akd_merge.sv
rtl/core/adc_ladder_key_debouncer_top.sv
dv/adc_ladder_key_debouncer_top_tb.sv
